// File: src/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared widths, character codes, status codes and offset slot indexes for
// the HTTP request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

	// Width of the running byte position and of the stored offsets.
	localparam int POSITION_BITS = 16;
	// Width of every offset and count field on the result channel.
	localparam int FIELD_W       = 16;
	localparam int URI_W         = 16;
	localparam int N_OFS         = 6;

	// Configuration port geometry.
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;
	localparam int REG_IDX_W     = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_URI_LIMIT = REG_IDX_W'(0);
	localparam logic [URI_W-1:0]     URI_LIMIT_RST = URI_W'(1024);

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_UPPER_H = 8'h48;

	// Offset slots, also the bit order of the captured mask.
	localparam int OFS_MB = 0;
	localparam int OFS_MF = 1;
	localparam int OFS_PB = 2;
	localparam int OFS_PF = 3;
	localparam int OFS_VB = 4;
	localparam int OFS_VF = 5;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_METHOD = 2'd1,
		ST_URI_LONG   = 2'd2,
		ST_BAD_BLANK  = 2'd3
	} status_t;

	typedef logic [POSITION_BITS-1:0] pos_t;

endpackage

// File: src/hrlp_in_if.sv
// ----------------------------------------------------------------------------
// hrlp_in_if
// Byte channel into the parser: one request buffer byte and its last flag.
// ----------------------------------------------------------------------------
interface hrlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// File: src/hrlp_out_if.sv
// ----------------------------------------------------------------------------
// hrlp_out_if
// Result channel of the parser: status, recorded offsets and buffer summary.
// ----------------------------------------------------------------------------
interface hrlp_out_if import hrlp_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic [FIELD_W-1:0] method_begin;
	logic [FIELD_W-1:0] method_finish;
	logic [FIELD_W-1:0] path_begin;
	logic [FIELD_W-1:0] path_finish;
	logic [FIELD_W-1:0] version_begin;
	logic [FIELD_W-1:0] version_finish;
	logic [N_OFS-1:0]   captured_mask;
	logic [FIELD_W-1:0] bytes_consumed;
	logic               reached_done;

	modport source (
		output valid, output status,
		output method_begin, output method_finish,
		output path_begin, output path_finish,
		output version_begin, output version_finish,
		output captured_mask, output bytes_consumed, output reached_done,
		input ready
	);
	modport sink (
		input valid, input status,
		input method_begin, input method_finish,
		input path_begin, input path_finish,
		input version_begin, input version_finish,
		input captured_mask, input bytes_consumed, input reached_done,
		output ready
	);
endinterface

// File: src/hrlp_cfg.sv
// ----------------------------------------------------------------------------
// hrlp_cfg
// APB register slave holding the URI length limit.
// ----------------------------------------------------------------------------
module hrlp_cfg import hrlp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [URI_W-1:0]   uri_limit
);

	logic [URI_W-1:0]     uri_limit_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uri_limit_q <= URI_LIMIT_RST;
		end else if (wr_en && reg_idx == REG_URI_LIMIT) begin
			uri_limit_q <= pwdata[URI_W-1:0];
		end
	end

	// Addresses past the register list read as zero.
	assign prdata    = (reg_idx == REG_URI_LIMIT) ?
		{{(PDATA_W-URI_W){1'b0}}, uri_limit_q} : '0;
	assign uri_limit = uri_limit_q;

endmodule

// File: src/http_request_line_parser_unit.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_unit
// Byte-serial scanner for an HTTP request line and its terminating blank line.
// Path: a byte accepted from the channel waits in the input register, and
// its result word is loaded into the result register and shown on the output.
// Throughput: one byte per cycle; the phase step is a single short
// decode. A result word that the receiver holds back keeps the next byte in
// the input register until the word is taken.
// Reset: arst_n clears the phase machine, counters and pipeline valids, and
// loads the URI limit with 1024.
// ----------------------------------------------------------------------------
module http_request_line_parser_unit import hrlp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	hrlp_in_if.sink            req,
	hrlp_out_if.source         res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// Phases of the request scan. The method, URI and version phases each
	// have an entry phase that decides between the expected opening byte
	// and the fall-through case.
	typedef enum logic [3:0] {
		PH_START,
		PH_METHOD,
		PH_BEFORE_URI,
		PH_URI,
		PH_BEFORE_VERSION,
		PH_VERSION,
		PH_LINE_CR,
		PH_LINE_DONE,
		PH_BLANK_CR,
		PH_DONE
	} phase_t;

	logic [URI_W-1:0] uri_limit;

	hrlp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.uri_limit (uri_limit)
	);

	// ---------------------------------------------------------------- input
	// The input register decouples the byte channel from the scan step.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       res_valid_q;
	logic       adv;

	// The scan step fires when a byte waits in the input register and the
	// result register is empty or being drained in this cycle.
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			last_s1  <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
			byte_s1  <= req.data_byte;
			last_s1  <= req.last;
		end
	end

	// ----------------------------------------------------------- scan state
	phase_t           phase_q;
	logic [URI_W-1:0] uri_cnt_q;
	pos_t             pos_q;
	pos_t             ofs_q [N_OFS];
	logic [N_OFS-1:0] ofs_valid_q;
	logic             skip_q;

	// Result register.
	status_t            status_q;
	logic [FIELD_W-1:0] res_ofs_q [N_OFS];
	logic [N_OFS-1:0]   mask_q;
	logic [FIELD_W-1:0] consumed_q;
	logic               done_q;

	// ----------------------------------------------------------- phase step
	phase_t           phase_n;
	logic [URI_W-1:0] uri_cnt_n;
	logic [N_OFS-1:0] rec;
	status_t          err;
	logic             is_upper;
	pos_t             pos_n;
	logic [N_OFS-1:0] ofs_valid_n;
	logic [FIELD_W-1:0] ofs_view [N_OFS];
	logic             res_load;

	assign is_upper = (byte_s1 >= CH_UPPER_A) && (byte_s1 <= CH_UPPER_Z);
	assign pos_n    = pos_q + pos_t'(1);

	always_comb begin
		phase_n   = phase_q;
		uri_cnt_n = uri_cnt_q;
		rec       = '0;
		err       = ST_OK;
		case (phase_q)
			PH_START: begin
				rec[OFS_MB] = 1'b1;
				// A bare CR or LF up front skips straight to the blank line.
				if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
					phase_n = PH_LINE_DONE;
				end else if (!is_upper) begin
					err = ST_BAD_METHOD;
				end else begin
					phase_n = PH_METHOD;
				end
			end
			PH_METHOD: begin
				if (byte_s1 == CH_SPACE) begin
					rec[OFS_MF] = 1'b1;
					phase_n     = PH_BEFORE_URI;
				end else if (!is_upper) begin
					err = ST_BAD_METHOD;
				end
			end
			PH_BEFORE_URI, PH_URI: begin
				if (phase_q == PH_BEFORE_URI && byte_s1 == CH_SLASH) begin
					rec[OFS_PB] = 1'b1;
					phase_n     = PH_URI;
				end else begin
					// Any other byte counts as URI, even before a slash.
					if (byte_s1 == CH_SPACE) begin
						rec[OFS_PF] = 1'b1;
						phase_n     = PH_BEFORE_VERSION;
					end
					if (uri_cnt_q > uri_limit) begin
						err = ST_URI_LONG;
					end else if (uri_cnt_q != '1) begin
						uri_cnt_n = uri_cnt_q + URI_W'(1);
					end
				end
			end
			PH_BEFORE_VERSION, PH_VERSION: begin
				if (phase_q == PH_BEFORE_VERSION && byte_s1 == CH_UPPER_H) begin
					rec[OFS_VB] = 1'b1;
					phase_n     = PH_VERSION;
				end else if (byte_s1 == CH_CR) begin
					rec[OFS_VF] = 1'b1;
					phase_n     = PH_LINE_CR;
				end
			end
			PH_LINE_CR: begin
				// Without the LF the scan keeps waiting for it.
				if (byte_s1 == CH_LF) begin
					phase_n = PH_LINE_DONE;
				end
			end
			PH_LINE_DONE: begin
				if (byte_s1 == CH_CR) begin
					phase_n = PH_BLANK_CR;
				end else begin
					err = ST_BAD_BLANK;
				end
			end
			PH_BLANK_CR: begin
				if (byte_s1 == CH_LF) begin
					phase_n = PH_DONE;
				end else begin
					err = ST_BAD_BLANK;
				end
			end
			default: begin
				// Done: trailing bytes are ignored until the buffer ends.
			end
		endcase
	end

	assign ofs_valid_n = ofs_valid_q | rec;

	// A result word is loaded for the first error of a buffer and for the
	// final byte of a buffer that is not being dropped.
	assign res_load = adv && !skip_q && (err != ST_OK || last_s1);

	// Offsets as the result word shows them: a slot recorded by this byte
	// carries the current position, a slot never recorded reads zero.
	always_comb begin
		for (int i = 0; i < N_OFS; i++) begin
			if (rec[i]) begin
				ofs_view[i] = FIELD_W'(pos_q);
			end else if (ofs_valid_q[i]) begin
				ofs_view[i] = FIELD_W'(ofs_q[i]);
			end else begin
				ofs_view[i] = '0;
			end
		end
	end

	// State and result register. The end of a buffer, whether it produces a
	// result or is dropped after an error, returns the scan to its start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			uri_cnt_q   <= '0;
			pos_q       <= '0;
			ofs_valid_q <= '0;
			skip_q      <= 1'b0;
			res_valid_q <= 1'b0;
			status_q    <= ST_OK;
			mask_q      <= '0;
			consumed_q  <= '0;
			done_q      <= 1'b0;
			for (int i = 0; i < N_OFS; i++) begin
				ofs_q[i]     <= '0;
				res_ofs_q[i] <= '0;
			end
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (adv) begin
				if (skip_q) begin
					if (last_s1) begin
						phase_q     <= PH_START;
						uri_cnt_q   <= '0;
						pos_q       <= '0;
						ofs_valid_q <= '0;
						skip_q      <= 1'b0;
					end
				end else begin
					for (int i = 0; i < N_OFS; i++) begin
						if (rec[i]) begin
							ofs_q[i] <= pos_q;
						end
					end
					if (res_load) begin
						status_q    <= err;
						mask_q      <= ofs_valid_n;
						for (int i = 0; i < N_OFS; i++) begin
							res_ofs_q[i] <= ofs_view[i];
						end
						if (err != ST_OK) begin
							consumed_q <= '0;
							done_q     <= 1'b0;
						end else begin
							consumed_q <= FIELD_W'(pos_n);
							done_q     <= (phase_n == PH_DONE);
						end
					end
					if (last_s1) begin
						phase_q     <= PH_START;
						uri_cnt_q   <= '0;
						pos_q       <= '0;
						ofs_valid_q <= '0;
						skip_q      <= 1'b0;
					end else begin
						phase_q     <= phase_n;
						uri_cnt_q   <= uri_cnt_n;
						pos_q       <= pos_n;
						ofs_valid_q <= ofs_valid_n;
						skip_q      <= (err != ST_OK);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- output
	assign res.valid          = res_valid_q;
	assign res.status         = status_q;
	assign res.method_begin   = res_ofs_q[OFS_MB];
	assign res.method_finish  = res_ofs_q[OFS_MF];
	assign res.path_begin     = res_ofs_q[OFS_PB];
	assign res.path_finish    = res_ofs_q[OFS_PF];
	assign res.version_begin  = res_ofs_q[OFS_VB];
	assign res.version_finish = res_ofs_q[OFS_VF];
	assign res.captured_mask  = mask_q;
	assign res.bytes_consumed = consumed_q;
	assign res.reached_done   = done_q;

	// ------------------------------------------------------------ assertions
	// A byte dropped after an error never produces a result word.
	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && skip_q && !res_valid_q |=> !res_valid_q)
		else $error("result produced while dropping bytes after an error");

	// The final byte of a buffer always returns the scan to its start.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == PH_START && pos_q == '0 &&
			ofs_valid_q == '0 && !skip_q && uri_cnt_q == '0)
		else $error("scan state not cleared at the end of a buffer");

	// An error word carries no length and no completion flag.
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q != ST_OK |-> consumed_q == '0 && !done_q)
		else $error("error word with length or completion set");

	// An error always leaves the scan either dropping bytes or restarted.
	a_err_skip: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !skip_q && err != ST_OK && !last_s1 |=> skip_q)
		else $error("error did not enter the drop mode");

endmodule
